FILE: rtl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants for the clock synthesiser frequency plan
// Word widths, plan constants and the beat that moves along the divider cells.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int FREQ_W     = 32;          // frequency arithmetic width
    localparam int DIV_W      = FREQ_W;      // width of one division cell
    localparam int XTAL_W     = 27;
    localparam int MINF_W     = 20;
    localparam int OFREQ_W    = 28;
    localparam int NUM_W      = 20;
    localparam int MSDIV_W    = 30;
    localparam int P1_W       = 18;
    localparam int BANDS      = 7;

    localparam int DIV1_STEPS = DIV_W;       // 900 MHz / scaled frequency
    localparam int DIV2_STEPS = DIV_W;       // PLL frequency / crystal
    localparam int DIV3_STEPS = NUM_W;       // fraction numerator

    localparam logic [DIV_W-1:0]    PLL_TARGET = DIV_W'(900000000);
    localparam logic [NUM_W:0]      FRAC_DENOM = 21'd1048575;
    localparam logic [P1_W-1:0]     P1_OFFSET  = 18'd512;

    localparam logic [1:0] REG_XTAL = 2'd0;
    localparam logic [1:0] REG_MINF = 2'd1;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvsr;
        logic [DIV_W-1:0] word;
    } t_div_beat;

    typedef struct packed {
        logic               sel;
        logic [2:0]         rexp;
        logic               bad;
        logic [FREQ_W-1:0]  scaled;
        logic [MSDIV_W-1:0] divider;
        logic [7:0]         mult;
    } t_side;

endpackage

FILE: rtl/cfp_div_cell.sv
// ----------------------------------------------------------------------------
// cfp_div_cell: one restoring division step
// Shift the next dividend bit into the partial remainder, subtract when it
// fits and shift the quotient bit into the word; register the beat.
// ----------------------------------------------------------------------------
module cfp_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfp_pkg::t_div_beat i_beat,
    output cfp_pkg::t_div_beat o_beat
);
    import cfp_pkg::*;

    t_div_beat        r_beat;
    t_div_beat        n_beat;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    always_comb begin
        trial        = {i_beat.rem, i_beat.word[DIV_W-1]};
        diff         = trial - {1'b0, i_beat.dvsr};
        fits         = (trial >= {1'b0, i_beat.dvsr});
        n_beat.valid = i_beat.valid;
        n_beat.dvsr  = i_beat.dvsr;
        n_beat.rem   = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        n_beat.word  = {i_beat.word[DIV_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.rem  <= n_beat.rem;
        r_beat.dvsr <= n_beat.dvsr;
        r_beat.word <= n_beat.word;
    end

    assign o_beat = r_beat;

endmodule

FILE: rtl/clock_synth_frequency_plan.sv
// ----------------------------------------------------------------------------
// clock_synth_frequency_plan: PLL and MultiSynth frequency plan
// Throughput: one request per cycle; busy never rises.
// Beats pass the input and band registers, then three rows of division cells,
// one bit per cell, split by the multiply and scale registers, to o_done.
// Synchronous active-low reset clears the valid bits and loads the register
// defaults; results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module clock_synth_frequency_plan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [cfp_pkg::OFREQ_W-1:0]   i_output_freq,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [cfp_pkg::XTAL_W-1:0]    i_cfg_data,
    output logic                          o_done,
    output logic                          o_chosen_output,
    output logic [2:0]                    o_r_div_exp,
    output logic [cfp_pkg::MSDIV_W-1:0]   o_ms_divider,
    output logic [cfp_pkg::P1_W-1:0]      o_ms_p1,
    output logic [7:0]                    o_pll_mult,
    output logic [cfp_pkg::NUM_W-1:0]     o_pll_num,
    output logic [cfp_pkg::P1_W-1:0]      o_pll_p1,
    output logic [cfp_pkg::NUM_W-1:0]     o_pll_p2,
    output logic                          o_bad_request
);
    import cfp_pkg::*;

    // Configuration registers: always ready, taken on every valid beat.
    logic [XTAL_W-1:0] r_xtal;
    logic [MINF_W-1:0] r_minf;
    logic [XTAL_W-1:0] xtal_eff;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xtal <= XTAL_W'(25000000);
            r_minf <= MINF_W'(4000);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_XTAL: r_xtal <= i_cfg_data;
                REG_MINF: r_minf <= i_cfg_data[MINF_W-1:0];
                default:  ;
            endcase
        end
    end

    // A zero crystal register counts as one hertz.
    assign xtal_eff = (r_xtal == '0) ? XTAL_W'(1) : r_xtal;

    // Input stage: capture the request beat.
    logic               r_in_valid;
    logic               r_in_sel;
    logic [OFREQ_W-1:0] r_in_freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
        r_in_sel  <= i_action;
        r_in_freq <= i_output_freq;
    end

    // Band pick: seven disjoint octave compares, scale by the same power of two.
    logic [2:0]        band_rexp;
    logic [FREQ_W-1:0] band_scaled;
    logic [OFREQ_W:0]  band_lo [BANDS];
    logic [OFREQ_W:0]  band_hi [BANDS];

    always_comb begin
        band_rexp   = 3'd0;
        band_scaled = FREQ_W'(r_in_freq);
        for (int k = 0; k < BANDS; k++) begin
            band_lo[k] = (OFREQ_W+1)'(r_minf) << k;
            band_hi[k] = (OFREQ_W+1)'(r_minf) << (k + 1);
            if (({1'b0, r_in_freq} >= band_lo[k]) && ({1'b0, r_in_freq} < band_hi[k])) begin
                band_rexp   = 3'(BANDS - k);
                band_scaled = FREQ_W'(r_in_freq) << (BANDS - k);
            end
        end
    end

    logic              r_bd_valid;
    logic              r_bd_sel;
    logic              r_bd_bad;
    logic [2:0]        r_bd_rexp;
    logic [FREQ_W-1:0] r_bd_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bd_valid <= 1'b0;
        end else begin
            r_bd_valid <= r_in_valid;
        end
        r_bd_sel    <= r_in_sel;
        r_bd_bad    <= (r_in_freq == '0);
        r_bd_rexp   <= band_rexp;
        r_bd_scaled <= band_scaled;
    end

    // First row: MultiSynth divider = 900 MHz / scaled frequency.
    t_div_beat c1 [DIV1_STEPS+1];
    t_side     s1 [DIV1_STEPS+1];

    always_comb begin
        c1[0].valid    = r_bd_valid;
        c1[0].rem      = '0;
        c1[0].dvsr     = r_bd_scaled;
        c1[0].word     = PLL_TARGET;
        s1[0].sel      = r_bd_sel;
        s1[0].rexp     = r_bd_rexp;
        s1[0].bad      = r_bd_bad;
        s1[0].scaled   = r_bd_scaled;
        s1[0].divider  = '0;
        s1[0].mult     = '0;
    end

    for (genvar g = 0; g < DIV1_STEPS; g++) begin : g_row1
        cfp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (c1[g]),
            .o_beat  (c1[g+1])
        );
        always_ff @(posedge i_clk) begin
            s1[g+1] <= s1[g];
        end
    end

    // Force the divider even, then form the PLL frequency (wraps to FREQ_W).
    logic [MSDIV_W-1:0] div_even;
    t_side              n_ml_side;
    logic               r_ml_valid;
    t_side              r_ml_side;
    logic [FREQ_W-1:0]  r_ml_pll;

    assign div_even = {c1[DIV1_STEPS].word[MSDIV_W-1:1], 1'b0};

    always_comb begin
        n_ml_side         = s1[DIV1_STEPS];
        n_ml_side.divider = div_even;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ml_valid <= 1'b0;
        end else begin
            r_ml_valid <= c1[DIV1_STEPS].valid;
        end
        r_ml_side <= n_ml_side;
        r_ml_pll  <= FREQ_W'(div_even * s1[DIV1_STEPS].scaled);
    end

    // Second row: PLL frequency / crystal gives multiplier and remainder.
    t_div_beat c2 [DIV2_STEPS+1];
    t_side     s2 [DIV2_STEPS+1];

    always_comb begin
        c2[0].valid = r_ml_valid;
        c2[0].rem   = '0;
        c2[0].dvsr  = DIV_W'(xtal_eff);
        c2[0].word  = r_ml_pll;
        s2[0]       = r_ml_side;
    end

    for (genvar g = 0; g < DIV2_STEPS; g++) begin : g_row2
        cfp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (c2[g]),
            .o_beat  (c2[g+1])
        );
        always_ff @(posedge i_clk) begin
            s2[g+1] <= s2[g];
        end
    end

    // Scale the remainder by the fraction denominator: rem * (2^20 - 1).
    localparam int SCL_W = XTAL_W + NUM_W;
    logic [SCL_W-1:0] rem_scaled;
    t_side            n_sc_side;
    logic             r_sc_valid;
    t_side            r_sc_side;
    logic [SCL_W-1:0] r_sc_val;

    assign rem_scaled = {c2[DIV2_STEPS].rem[XTAL_W-1:0], NUM_W'(0)}
                      - SCL_W'(c2[DIV2_STEPS].rem[XTAL_W-1:0]);

    always_comb begin
        n_sc_side      = s2[DIV2_STEPS];
        n_sc_side.mult = c2[DIV2_STEPS].word[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_valid <= 1'b0;
        end else begin
            r_sc_valid <= c2[DIV2_STEPS].valid;
        end
        r_sc_side <= n_sc_side;
        r_sc_val  <= rem_scaled;
    end

    // Third row: numerator = scaled remainder / crystal. The upper part is
    // already below the crystal, so only the low bits need a step each.
    t_div_beat c3 [DIV3_STEPS+1];
    t_side     s3 [DIV3_STEPS+1];

    always_comb begin
        c3[0].valid = r_sc_valid;
        c3[0].rem   = DIV_W'(r_sc_val[SCL_W-1:NUM_W]);
        c3[0].dvsr  = DIV_W'(xtal_eff);
        c3[0].word  = {r_sc_val[NUM_W-1:0], (DIV_W-NUM_W)'(0)};
        s3[0]       = r_sc_side;
    end

    for (genvar g = 0; g < DIV3_STEPS; g++) begin : g_row3
        cfp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (c3[g]),
            .o_beat  (c3[g+1])
        );
        always_ff @(posedge i_clk) begin
            s3[g+1] <= s3[g];
        end
    end

    // Pack P1/P2: 128*num over 2^20-1 by fold-and-correct, one compare.
    t_side             sf;
    logic [NUM_W-1:0]  num;
    logic [6:0]        fq;
    logic [NUM_W:0]    fr;
    logic [7:0]        frac;
    logic [NUM_W-1:0]  p2;
    logic [P1_W-1:0]   p1;
    logic [P1_W-1:0]   ms1;

    always_comb begin
        sf  = s3[DIV3_STEPS];
        num = c3[DIV3_STEPS].word[NUM_W-1:0];
        fq  = num[NUM_W-1:NUM_W-7];
        fr  = {1'b0, num[NUM_W-8:0], 7'd0} + (NUM_W+1)'(fq);
        if (fr >= FRAC_DENOM) begin
            frac = {1'b0, fq} + 8'd1;
            p2   = NUM_W'(fr - FRAC_DENOM);
        end else begin
            frac = {1'b0, fq};
            p2   = fr[NUM_W-1:0];
        end
        p1  = P1_W'({sf.mult, 7'd0}) + P1_W'(frac) - P1_OFFSET;
        ms1 = {sf.divider[P1_W-8:0], 7'd0} - P1_OFFSET;
    end

    // Output register: a bad request zeroes every field but its flag.
    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= c3[DIV3_STEPS].valid;
        end
        o_bad_request   <= sf.bad;
        o_chosen_output <= sf.bad ? 1'b0 : sf.sel;
        o_r_div_exp     <= sf.bad ? '0 : sf.rexp;
        o_ms_divider    <= sf.bad ? '0 : sf.divider;
        o_ms_p1         <= sf.bad ? '0 : ms1;
        o_pll_mult      <= sf.bad ? '0 : sf.mult;
        o_pll_num       <= sf.bad ? '0 : num;
        o_pll_p1        <= sf.bad ? '0 : p1;
        o_pll_p2        <= sf.bad ? '0 : p2;
    end

    assign o_done = r_done;

endmodule
